>>> hw/rtl/rrdf_pkg.sv
package rrdf_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_INTERVAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TVOC_LIMIT      = 1'd1;

    localparam logic [15:0] INTERVAL_RESET = 16'd5000;
    localparam logic [9:0]  LIMIT_RESET    = 10'd999;

    // Item commands
    localparam logic CMD_READING = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    // Screens
    localparam logic [1:0] SCR_TEMP = 2'd0;
    localparam logic [1:0] SCR_HUM  = 2'd1;
    localparam logic [1:0] SCR_AIR  = 2'd2;

    // Queue depths
    localparam int JOB_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 4;

    // Reciprocal of ten for 21-bit magnitudes: q = (n * RECIP10) >> 24
    localparam logic [20:0] RECIP10 = 21'h19999A;

    // Segment glyphs, bit0 = A .. bit6 = G
    localparam logic [6:0] GL_BLANK  = 7'h00;
    localparam logic [6:0] GL_MINUS  = 7'h40;
    localparam logic [6:0] GL_DEGREE = 7'h63;
    localparam logic [6:0] GL_C      = 7'h39;
    localparam logic [6:0] GL_R      = 7'h50;
    localparam logic [6:0] GL_H      = 7'h74;
    localparam logic [6:0] GL_B      = 7'h7C;
    localparam logic [6:0] GL_L      = 7'h30;
    localparam logic [6:0] GL_O      = 7'h5C;

    localparam logic [20:0] TVOC_RESET = -21'sd10;

    typedef struct packed {
        logic [1:0]         screen;
        logic signed [11:0] temp;
        logic [9:0]         hum;
        logic signed [20:0] tvoc;
        logic               tvoc_ok;
    } t_job;

    typedef struct packed {
        logic [6:0] d0;
        logic [6:0] d1;
        logic [6:0] d2;
        logic [6:0] d3;
        logic [1:0] screen;
    } t_result;

    function automatic logic [6:0] seg_digit(input logic [3:0] d);
        logic [6:0] g;
        case (d)
            4'd0:    g = 7'h3F;
            4'd1:    g = 7'h06;
            4'd2:    g = 7'h5B;
            4'd3:    g = 7'h4F;
            4'd4:    g = 7'h66;
            4'd5:    g = 7'h6D;
            4'd6:    g = 7'h7D;
            4'd7:    g = 7'h07;
            4'd8:    g = 7'h7F;
            4'd9:    g = 7'h6F;
            default: g = GL_BLANK;
        endcase
        return g;
    endfunction

endpackage

>>> hw/rtl/rotating_reading_display_formatter.sv
// Rotating reading display formatter: drives four seven-segment digits.
//
// Input channel (push/full): each item is either a reading (command 0) that
// latches temperature, humidity and TVOC, or a tick (command 1) carrying the
// millisecond time. A reading always yields one result; a tick yields one
// only after a reading exists and the wrapping time since the last switch
// reaches rotate_interval_ms, in which case the screen advances 0,1,2,0.
// Result channel (empty/pop): four segment patterns and the shown screen.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx at once.
//
// Path: an accepted item is written to the job queue at the accepting edge,
// then passes two stage registers in the rounding/digit pipeline, then the
// result queue, whose head drives the result ports. While the receiver pops,
// one item per cycle is sustained; the rate is set by the front, which
// updates its state for each accepted item, and the fully pipelined back
// end. When the receiver stalls, results collect in the result queue, the
// back end stops drawing jobs once queue plus in-flight items fill it, and
// full rises when the job queue is full. Synchronous reset empties both
// queues and returns the screen, timer and held readings to their defaults.
module rotating_reading_display_formatter #(
    parameter int JOB_DEPTH = rrdf_pkg::JOB_DEPTH_DEF,
    parameter int OUT_DEPTH = rrdf_pkg::OUT_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input item channel
    input  logic                              push,
    output logic                              full,
    input  logic                              i_command,
    input  logic signed [11:0]                i_temp_tenths,
    input  logic [9:0]                        i_hum_tenths,
    input  logic signed [20:0]                i_tvoc_tenths,
    input  logic                              i_tvoc_ok,
    input  logic [31:0]                       i_now_ms,
    // Result item channel
    output logic                              empty,
    input  logic                              pop,
    output logic [6:0]                        o_digit0_pattern,
    output logic [6:0]                        o_digit1_pattern,
    output logic [6:0]                        o_digit2_pattern,
    output logic [6:0]                        o_digit3_pattern,
    output logic [1:0]                        o_shown_screen,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [rrdf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rrdf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import rrdf_pkg::*;

    localparam int JW = $bits(t_job);

    logic [15:0]   r_interval;
    logic [9:0]    r_limit;

    logic          w_accept;
    logic          w_job_push;
    t_job          w_job_in;
    logic          w_data_seen;
    logic [JW-1:0] w_job_q;
    logic          w_job_empty;
    logic          w_job_pop;
    t_result       w_res;

    // Take an item whenever the job queue has room
    assign w_accept = push && !full;

    // Configuration registers; the user must write them only while the block is idle (the block does not enforce it)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RESET;
            r_limit    <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROTATE_INTERVAL: r_interval <= i_cfg_data[15:0];
                CFG_TVOC_LIMIT:      r_limit    <= i_cfg_data[9:0];
                default:             r_limit    <= r_limit;
            endcase
        end
    end

    // Front: hold readings, run the rotation timer, issue render jobs
    rrdf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_command     (i_command),
        .i_temp_tenths (i_temp_tenths),
        .i_hum_tenths  (i_hum_tenths),
        .i_tvoc_tenths (i_tvoc_tenths),
        .i_tvoc_ok     (i_tvoc_ok),
        .i_now_ms      (i_now_ms),
        .i_interval    (r_interval),
        .o_job_push    (w_job_push),
        .o_job         (w_job_in),
        .o_data_seen   (w_data_seen)
    );

    // Short job queue decouples the front from the render pipeline
    rrdf_fifo #(
        .WIDTH (JW),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_data  (w_job_in),
        .i_pop   (w_job_pop),
        .o_data  (w_job_q),
        .o_empty (w_job_empty),
        .o_full  (full),
        .o_count ()
    );

    // Back: round, clamp, split digits, map glyphs, queue results
    rrdf_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limit     (r_limit),
        .i_job       (t_job'(w_job_q)),
        .i_job_empty (w_job_empty),
        .o_job_pop   (w_job_pop),
        .i_pop       (pop),
        .o_result    (w_res),
        .o_empty     (empty)
    );

    assign o_digit0_pattern = w_res.d0;
    assign o_digit1_pattern = w_res.d1;
    assign o_digit2_pattern = w_res.d2;
    assign o_digit3_pattern = w_res.d3;
    assign o_shown_screen   = w_res.screen;

`ifndef SYNTH
    // A reading always leaves a job behind for the back end
    a_reading_queues_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_command == CMD_READING)) |=> !w_job_empty)
        else $error("reading item did not queue a render job");

    // A tick before any reading must not render
    a_tick_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_command == CMD_TICK) && !w_data_seen) |-> !w_job_push)
        else $error("tick rendered before any reading was held");

    // Only three screens exist
    a_screen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_shown_screen != 2'd3))
        else $error("result shows an undefined screen");
`endif

endmodule

>>> hw/rtl/rrdf_fifo.sv
module rrdf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_data,
    output logic                         o_empty,
    output logic                         o_full,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CW-1:0]    r_cnt;
    logic             w_wr;
    logic             w_rd;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= (r_wptr == PW'(DEPTH-1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= (r_rptr == PW'(DEPTH-1)) ? '0 : r_rptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> hw/rtl/rrdf_front.sv
module rrdf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_command,
    input  logic signed [11:0]  i_temp_tenths,
    input  logic [9:0]          i_hum_tenths,
    input  logic signed [20:0]  i_tvoc_tenths,
    input  logic                i_tvoc_ok,
    input  logic [31:0]         i_now_ms,
    input  logic [15:0]         i_interval,
    output logic                o_job_push,
    output rrdf_pkg::t_job      o_job,
    output logic                o_data_seen
);
    import rrdf_pkg::*;

    logic [1:0]         r_screen;
    logic               r_data_seen;
    logic [31:0]        r_last_ms;
    logic signed [11:0] r_temp;
    logic [9:0]         r_hum;
    logic signed [20:0] r_tvoc;
    logic               r_tvoc_ok;

    logic [31:0] w_elapsed;
    logic        w_fire;
    logic [1:0]  n_screen_adv;
    logic [1:0]  n_screen;

    assign w_elapsed = i_now_ms - r_last_ms;
    assign w_fire    = r_data_seen && (w_elapsed >= 32'(i_interval));

    always_comb begin
        unique case (r_screen)
            SCR_TEMP: n_screen_adv = SCR_HUM;
            SCR_HUM:  n_screen_adv = SCR_AIR;
            SCR_AIR:  n_screen_adv = SCR_TEMP;
            default:  n_screen_adv = SCR_HUM;
        endcase
    end

    // Screen after this item
    always_comb begin
        if (i_command == CMD_READING) begin
            n_screen = r_data_seen ? r_screen : SCR_TEMP;
        end else begin
            n_screen = w_fire ? n_screen_adv : r_screen;
        end
    end

    always_comb begin
        o_job_push = i_accept && ((i_command == CMD_READING) || w_fire);
        if (i_command == CMD_READING) begin
            o_job.temp    = i_temp_tenths;
            o_job.hum     = i_hum_tenths;
            o_job.tvoc    = i_tvoc_tenths;
            o_job.tvoc_ok = i_tvoc_ok;
        end else begin
            o_job.temp    = r_temp;
            o_job.hum     = r_hum;
            o_job.tvoc    = r_tvoc;
            o_job.tvoc_ok = r_tvoc_ok;
        end
        o_job.screen = n_screen;
    end

    assign o_data_seen = r_data_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen    <= SCR_TEMP;
            r_data_seen <= 1'b0;
            r_last_ms   <= '0;
            r_temp      <= '0;
            r_hum       <= '0;
            r_tvoc      <= TVOC_RESET;
            r_tvoc_ok   <= 1'b0;
        end else if (i_accept) begin
            r_screen <= n_screen;
            if (i_command == CMD_READING) begin
                r_data_seen <= 1'b1;
                r_temp      <= i_temp_tenths;
                r_hum       <= i_hum_tenths;
                r_tvoc      <= i_tvoc_tenths;
                r_tvoc_ok   <= i_tvoc_ok;
            end else if (w_fire) begin
                r_last_ms <= i_now_ms;
            end
        end
    end

endmodule

>>> hw/rtl/rrdf_back.sv
module rrdf_back #(
    parameter int OUT_DEPTH = rrdf_pkg::OUT_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [9:0]        i_limit,
    input  rrdf_pkg::t_job    i_job,
    input  logic              i_job_empty,
    output logic              o_job_pop,
    input  logic              i_pop,
    output rrdf_pkg::t_result o_result,
    output logic              o_empty
);
    import rrdf_pkg::*;

    localparam int CW = $clog2(OUT_DEPTH+1);
    localparam int RW = $bits(t_result);

    // Credit check against result queue space
    logic [CW-1:0] w_ocnt;
    logic [CW:0]   w_used;
    logic          w_issue;

    // Stage 1: round to integer
    logic signed [20:0] n_x;
    logic [20:0]        w_mag;
    logic [20:0]        w_mag5;
    logic [41:0]        w_prod;
    logic               r_s1_v;
    logic [1:0]         r_s1_screen;
    logic               r_s1_neg;
    logic [16:0]        r_s1_rnd;
    logic               r_s1_bad;

    // Stage 2: clamp (or check against the TVOC limit) and divide
    logic               n_tneg;
    logic               n_lo;
    logic [9:0]         n_c;
    logic [17:0]        w_p10;
    logic [15:0]        w_p100;
    logic               r_s2_v;
    logic [1:0]         r_s2_screen;
    logic               r_s2_tneg;
    logic               r_s2_lo;
    logic               r_s2_bad;
    logic [9:0]         r_s2_c;
    logic [6:0]         r_s2_q10;
    logic [3:0]         r_s2_q100;

    // Stage 3: digits and glyphs
    logic [9:0]         w_ones_f;
    logic [6:0]         w_tens_f;
    logic [3:0]         w_ones;
    logic [3:0]         w_tens;
    logic [3:0]         w_hund;
    t_result            n_res;
    logic [RW-1:0]      w_odata;

    assign w_used    = {1'b0, w_ocnt} + (CW+1)'(r_s1_v) + (CW+1)'(r_s2_v);
    assign w_issue   = !i_job_empty && (w_used < (CW+1)'(OUT_DEPTH));
    assign o_job_pop = w_issue;

    always_comb begin
        case (i_job.screen)
            SCR_TEMP: n_x = 21'(i_job.temp);
            SCR_HUM:  n_x = signed'(21'(i_job.hum));
            default:  n_x = i_job.tvoc;
        endcase
        w_mag  = n_x[20] ? (~n_x + 21'd1) : n_x;
        w_mag5 = w_mag + 21'd5;
        w_prod = 42'(w_mag5) * 42'(RECIP10);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_screen <= i_job.screen;
        r_s1_neg    <= n_x[20];
        r_s1_rnd    <= w_prod[40:24];
        r_s1_bad    <= !i_job.tvoc_ok || i_job.tvoc[20];
    end

    always_comb begin
        n_tneg = 1'b0;
        n_lo   = 1'b0;
        case (r_s1_screen)
            SCR_TEMP: begin
                if (r_s1_neg && (r_s1_rnd != '0)) begin
                    n_tneg = 1'b1;
                    n_c    = (r_s1_rnd > 17'd9) ? 10'd9 : r_s1_rnd[9:0];
                end else begin
                    n_c    = (r_s1_rnd > 17'd99) ? 10'd99 : r_s1_rnd[9:0];
                end
            end
            SCR_HUM: begin
                n_c = (r_s1_rnd > 17'd99) ? 10'd99 : r_s1_rnd[9:0];
            end
            default: begin
                n_lo = r_s1_rnd > 17'(i_limit);
                n_c  = r_s1_rnd[9:0];
            end
        endcase
        w_p10  = 18'(n_c) * 18'd205;
        w_p100 = 16'(n_c) * 16'd41;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_screen <= r_s1_screen;
        r_s2_tneg   <= n_tneg;
        r_s2_lo     <= n_lo;
        r_s2_bad    <= r_s1_bad;
        r_s2_c      <= n_c;
        r_s2_q10    <= w_p10[17:11];
        r_s2_q100   <= w_p100[15:12];
    end

    always_comb begin
        w_ones_f = r_s2_c - 10'(r_s2_q10) * 10'd10;
        w_tens_f = r_s2_q10 - 7'(r_s2_q100) * 7'd10;
        w_ones   = w_ones_f[3:0];
        w_tens   = w_tens_f[3:0];
        w_hund   = (r_s2_q100 >= 4'd10) ? (r_s2_q100 - 4'd10) : r_s2_q100;

        n_res.screen = r_s2_screen;
        case (r_s2_screen)
            SCR_TEMP: begin
                if (r_s2_tneg) begin
                    n_res.d0 = GL_MINUS;
                    n_res.d1 = seg_digit(w_ones);
                end else if (r_s2_c < 10'd10) begin
                    n_res.d0 = GL_BLANK;
                    n_res.d1 = seg_digit(w_ones);
                end else begin
                    n_res.d0 = seg_digit(w_tens);
                    n_res.d1 = seg_digit(w_ones);
                end
                n_res.d2 = GL_DEGREE;
                n_res.d3 = GL_C;
            end
            SCR_HUM: begin
                n_res.d0 = (r_s2_c < 10'd10) ? GL_BLANK : seg_digit(w_tens);
                n_res.d1 = seg_digit(w_ones);
                n_res.d2 = GL_R;
                n_res.d3 = GL_H;
            end
            default: begin
                n_res.d3 = GL_B;
                if (r_s2_bad) begin
                    n_res.d0 = GL_MINUS;
                    n_res.d1 = GL_MINUS;
                    n_res.d2 = GL_BLANK;
                end else if (r_s2_lo) begin
                    n_res.d0 = GL_L;
                    n_res.d1 = GL_O;
                    n_res.d2 = GL_BLANK;
                end else begin
                    if (r_s2_c >= 10'd100) begin
                        n_res.d0 = seg_digit(w_hund);
                        n_res.d1 = seg_digit(w_tens);
                    end else if (r_s2_c >= 10'd10) begin
                        n_res.d0 = GL_BLANK;
                        n_res.d1 = seg_digit(w_tens);
                    end else begin
                        n_res.d0 = GL_BLANK;
                        n_res.d1 = GL_BLANK;
                    end
                    n_res.d2 = seg_digit(w_ones);
                end
            end
        endcase
    end

    rrdf_fifo #(
        .WIDTH (RW),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_v),
        .i_data  (n_res),
        .i_pop   (i_pop),
        .o_data  (w_odata),
        .o_empty (o_empty),
        .o_full  (),
        .o_count (w_ocnt)
    );

    assign o_result = t_result'(w_odata);

endmodule
